FILE: hdl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared constants, codes and types of the keypad press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int NUM_BUTTONS_DEF = 9;
    localparam int MAX_BUTTONS     = 9;

    localparam int CODE_W  = 8;
    localparam int PHASE_W = 2;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int BTN_W   = 4;
    localparam int MS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CODE_W-1:0] KEY_FIRST = 8'h31;
    localparam logic [CODE_W-1:0] KEY_LAST  = 8'h39;

    localparam logic [PHASE_W-1:0] PHASE_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PRESSED  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_HOLD     = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_RELEASED = 2'd3;

    localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EV_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG  = 2'd2;
    localparam logic [KIND_W-1:0] EV_COMBO = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_0_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_4_7    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_8      = 3'd5;

    localparam logic [MS_W-1:0]        SHORT_MAX_RST   = 16'd500;
    localparam logic [MS_W-1:0]        REPEAT_INT_RST  = 16'd100;
    localparam logic [MAX_BUTTONS-1:0] REPEAT_MASK_RST = '0;
    localparam logic [63:0]            LONG_PACKED_RST = 64'h01F4_01F4_01F4_01F4;
    localparam logic [MS_W-1:0]        LONG_8_RST      = 16'd500;

    typedef struct packed {
        logic [MS_W-1:0]        short_max;
        logic [MS_W-1:0]        repeat_int;
        logic [MAX_BUTTONS-1:0] repeat_mask;
        logic [63:0]            long_0_3;
        logic [63:0]            long_4_7;
        logic [MS_W-1:0]        long_8;
    } kpc_cfg_t;

endpackage

FILE: hdl/kpc_cfg.sv
// ----------------------------------------------------------------------------
// kpc_cfg
// Configuration register file: decodes writes, holds the timing registers.
// ----------------------------------------------------------------------------
module kpc_cfg
    import kpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output kpc_cfg_t              cfg
);

    kpc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_max   <= SHORT_MAX_RST;
            cfg_reg.repeat_int  <= REPEAT_INT_RST;
            cfg_reg.repeat_mask <= REPEAT_MASK_RST;
            cfg_reg.long_0_3    <= LONG_PACKED_RST;
            cfg_reg.long_4_7    <= LONG_PACKED_RST;
            cfg_reg.long_8      <= LONG_8_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SHORT_MAX:   cfg_reg.short_max   <= cfg_data[MS_W-1:0];
                REG_REPEAT_INT:  cfg_reg.repeat_int  <= cfg_data[MS_W-1:0];
                REG_REPEAT_MASK: cfg_reg.repeat_mask <= cfg_data[MAX_BUTTONS-1:0];
                REG_LONG_0_3:    cfg_reg.long_0_3    <= cfg_data;
                REG_LONG_4_7:    cfg_reg.long_4_7    <= cfg_data;
                REG_LONG_8:      cfg_reg.long_8      <= cfg_data[MS_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

FILE: hdl/keypad_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// keypad_press_classifier_unit
// Turns keypad scanner reports into short, long and combo press events.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per key report:
//   key_code, key_phase, now_ms. Output channel (out_valid/out_ready)
//   returns exactly one word per report: event_kind, event_button,
//   held_button, all_idle. Config channel (cfg_valid/cfg_ready, always
//   ready) writes register cfg_index with cfg_data; write only when idle.
//   The output word is registered at the end of stage 1 and held until taken.
//   Throughput is one word per cycle unless the receiver stalls: stage 0
//   reads the per-button time entry from a one-port-read synchronous
//   memory, stage 1 classifies, updates flags and writes the entry back;
//   a same-entry write bypasses into the read.
//   When the receiver stalls, the output register holds; a word waiting
//   in stage 1 holds too, and in_ready drops until the output word is taken.
//   Reset clears all flags and loads register defaults; time entries are
//   always written on a press before their values are used, so no clearing pass.
// ----------------------------------------------------------------------------
module keypad_press_classifier_unit
    import kpc_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CODE_W-1:0]     key_code,
    input  logic [PHASE_W-1:0]    key_phase,
    input  logic [TIME_W-1:0]     now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     event_kind,
    output logic [BTN_W-1:0]      event_button,
    output logic [BTN_W-1:0]      held_button,
    output logic                  all_idle,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    kpc_cfg_t cfg;

    kpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // time store: {last_repeat_time, press_time}
    logic [2*TIME_W-1:0] mem [NUM_BUTTONS];
    logic [2*TIME_W-1:0] rd_data_reg;

    logic s1_valid_reg;
    logic s1_hit_reg;
    logic [IDX_W-1:0] s1_btn_reg;
    logic [PHASE_W-1:0] s1_phase_reg;
    logic [TIME_W-1:0] s1_now_reg;

    logic [NUM_BUTTONS-1:0] active_reg, active_next;
    logic [NUM_BUTTONS-1:0] long_reg, long_next;
    logic [NUM_BUTTONS-1:0] combo_reg, combo_next;

    logic out_valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BTN_W-1:0] ev_btn_reg, ev_btn_next;
    logic [BTN_W-1:0] held_reg, held_next;
    logic idle_reg;

    logic in_fire, s1_fire;
    logic [CODE_W-1:0] key_off;
    logic in_hit;
    logic [IDX_W-1:0] in_btn;
    logic rd_en;

    logic wr_en;
    logic [2*TIME_W-1:0] wr_data;

    // stage 0
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;
    assign key_off  = key_code - KEY_FIRST;
    assign in_hit   = (key_code >= KEY_FIRST) && (key_code <= KEY_LAST)
                      && (key_off < CODE_W'(NUM_BUTTONS));
    assign in_btn   = key_off[IDX_W-1:0];
    assign rd_en    = in_fire && in_hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_btn_reg] <= wr_data;
        if (rd_en)
        begin
            if (wr_en && (s1_btn_reg == in_btn))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[in_btn];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_hit_reg   <= in_hit;
            s1_btn_reg   <= in_btn;
            s1_phase_reg <= key_phase;
            s1_now_reg   <= now_ms;
        end
    end

    // stage 1
    logic [MS_W-1:0] long_lim [NUM_BUTTONS];
    logic [TIME_W-1:0] press_t, rep_t, held_ms, rep_ms;
    logic [NUM_BUTTONS-1:0] bmask, others;
    logic act, rep, done_any;
    logic found;
    logic [IDX_W-1:0] held_idx;
    logic [MAX_BUTTONS-1:0] rep_mask_ext;

    always_comb
    begin
        for (int g = 0; g < NUM_BUTTONS; g++)
        begin
            if (g < 4)
                long_lim[g] = cfg.long_0_3[16*g +: 16];
            else if (g < 8)
                long_lim[g] = cfg.long_4_7[16*(g-4) +: 16];
            else
                long_lim[g] = cfg.long_8;
        end
    end

    assign press_t      = rd_data_reg[TIME_W-1:0];
    assign rep_t        = rd_data_reg[2*TIME_W-1:TIME_W];
    assign held_ms      = s1_now_reg - press_t;
    assign rep_ms       = s1_now_reg - rep_t;
    assign bmask        = NUM_BUTTONS'(1) << s1_btn_reg;
    assign others       = active_reg & ~bmask;
    assign act          = active_reg[s1_btn_reg];
    assign rep_mask_ext = cfg.repeat_mask;
    assign rep          = rep_mask_ext[s1_btn_reg];
    assign done_any     = long_reg[s1_btn_reg] || combo_reg[s1_btn_reg];

    always_comb
    begin
        found    = 1'b0;
        held_idx = '0;
        for (int j = NUM_BUTTONS - 1; j >= 0; j--)
        begin
            if (others[j])
            begin
                found    = 1'b1;
                held_idx = IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        long_next   = long_reg;
        combo_next  = combo_reg;
        kind_next   = EV_NONE;
        ev_btn_next = '0;
        held_next   = '0;
        wr_en       = 1'b0;
        wr_data     = {s1_now_reg, s1_now_reg};
        if (s1_fire && s1_hit_reg)
        begin
            case (s1_phase_reg)
                PHASE_PRESSED:
                begin
                    if (!act)
                    begin
                        wr_en       = 1'b1;
                        active_next = active_reg | bmask;
                        long_next   = long_reg & ~bmask;
                        combo_next  = combo_reg & ~bmask;
                        if (found)
                        begin
                            kind_next   = EV_COMBO;
                            ev_btn_next = BTN_W'(s1_btn_reg);
                            held_next   = BTN_W'(held_idx);
                            combo_next  = (combo_reg & ~bmask) | bmask
                                          | (NUM_BUTTONS'(1) << held_idx);
                        end
                        else if (rep)
                        begin
                            kind_next   = EV_SHORT;
                            ev_btn_next = BTN_W'(s1_btn_reg);
                        end
                    end
                end
                PHASE_HOLD:
                begin
                    if (act)
                    begin
                        if (rep)
                        begin
                            if ((held_ms >= TIME_W'(cfg.short_max))
                                && (rep_ms >= TIME_W'(cfg.repeat_int)))
                            begin
                                kind_next   = EV_SHORT;
                                ev_btn_next = BTN_W'(s1_btn_reg);
                                wr_en       = 1'b1;
                                wr_data     = {s1_now_reg, press_t};
                            end
                        end
                        else if (!done_any
                                 && (held_ms >= TIME_W'(long_lim[s1_btn_reg])))
                        begin
                            kind_next   = EV_LONG;
                            ev_btn_next = BTN_W'(s1_btn_reg);
                            long_next   = long_reg | bmask;
                        end
                    end
                end
                default:
                begin
                    // idle and released
                    if (act)
                    begin
                        active_next = active_reg & ~bmask;
                        if (!done_any && !rep
                            && (held_ms < TIME_W'(cfg.short_max)))
                        begin
                            kind_next   = EV_SHORT;
                            ev_btn_next = BTN_W'(s1_btn_reg);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
            long_reg      <= '0;
            combo_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            active_reg <= active_next;
            long_reg   <= long_next;
            combo_reg  <= combo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            kind_reg   <= kind_next;
            ev_btn_reg <= ev_btn_next;
            held_reg   <= held_next;
            idle_reg   <= (active_next == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign event_button = ev_btn_reg;
    assign held_button  = held_reg;
    assign all_idle     = idle_reg;

`ifndef ASSERT_OFF
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_NONE) |-> (event_button == '0) && (held_button == '0))
        else $error("no-event word carries a button");

    a_combo_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_COMBO) |-> (event_button != held_button))
        else $error("combo names the same button twice");

    a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (all_idle == (active_reg == '0)))
        else $error("all_idle disagrees with active flags");

    a_active_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((event_kind == EV_LONG) || (event_kind == EV_COMBO)) |-> !all_idle)
        else $error("long or combo reported with no active button");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline is stalled");
`endif

endmodule
